[rtl/core/exp_chi_squared_kernel_defines.svh]
// assertion macros for the exponential chi-squared kernel checker
// no dependencies; included by the checker file only
`ifndef EXP_CHI_SQUARED_KERNEL_DEFINES_SVH
`define EXP_CHI_SQUARED_KERNEL_DEFINES_SVH

// property checked only out of reset
`define ECSK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ecsk assertion failed");

// property that also spans the reset itself
`define ECSK_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ecsk reset assertion failed");

`endif

[rtl/core/ecsk_pkg.sv]
// shared types and constants of the exponential chi-squared kernel
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ecsk_pkg;

    // element pair after classification in the front end
    typedef struct packed {
        logic [15:0] diff;
        logic [16:0] total;
        logic        last;
    } t_pair;

    // finished sum handed from accumulator to exponential unit
    typedef struct packed {
        logic        valid;
        logic [22:0] sum;
    } t_sum_req;

    localparam logic [22:0] ACC_MAX     = 23'h7F_FFFF;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [4:0]  N_TERMS     = 5'd20;
    localparam logic [10:0] EXP_CUTOFF  = 11'd12;
    localparam logic [31:0] ROUND_BIAS  = 32'd8192;
    localparam logic [17:0] KERNEL_ONE  = 18'd65536;
    localparam logic [15:0] GAMMA_RESET = 16'd2048;
    localparam logic [4:0]  TERM_STEPS  = 5'd19;
    localparam logic [4:0]  SER_STEPS   = 5'd31;

endpackage

`default_nettype wire

[rtl/core/ecsk_front.sv]
// front end: accepts element pairs, forms |x-y| and x+y, queues them
// depends on ecsk_pkg
`timescale 1ns / 1ps
`default_nettype none

module ecsk_front #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_x_value,
    input  logic [15:0]        i_y_value,
    input  logic               i_last_element,
    output logic               o_pair_valid,
    output ecsk_pkg::t_pair    o_pair,
    input  logic               i_pair_pop
);
    import ecsk_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_pair         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic          push;
    logic          pop;
    t_pair         entry;

    assign o_stall      = (r_count == AW'(0) + (AW+1)'(DEPTH));
    assign push         = i_valid && !o_stall;
    assign o_pair_valid = (r_count != '0);
    assign pop          = i_pair_pop && o_pair_valid;
    assign o_pair       = r_mem[r_rd_ptr];

    always_comb begin
        entry.diff  = (i_x_value >= i_y_value) ? (i_x_value - i_y_value)
                                               : (i_y_value - i_x_value);
        entry.total = {1'b0, i_x_value} + {1'b0, i_y_value};
        entry.last  = i_last_element;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/ecsk_accum.sv]
// back end: chi-squared term by shift-subtract division, saturating sum
// depends on ecsk_pkg
`timescale 1ns / 1ps
`default_nettype none

module ecsk_accum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pair_valid,
    input  ecsk_pkg::t_pair     i_pair,
    output logic                o_pair_pop,
    output ecsk_pkg::t_sum_req  o_req,
    input  logic                i_req_ready
);
    import ecsk_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_ACC} t_state;

    t_state      r_state;
    logic [15:0] r_diff;
    logic [16:0] r_total;
    logic        r_last;
    logic [16:0] r_rem;
    logic [18:0] r_low;
    logic [18:0] r_quo;
    logic [4:0]  r_cnt;
    logic [22:0] r_acc;

    logic [31:0] prod;
    logic [17:0] trial;
    logic        ge;
    logic [17:0] diff_t;
    logic [23:0] sum_w;
    logic [22:0] sum_sat;

    assign prod    = r_diff * r_diff;
    assign trial   = {r_rem, r_low[18]};
    assign ge      = (trial >= {1'b0, r_total});
    assign diff_t  = trial - {1'b0, r_total};
    assign sum_w   = {1'b0, r_acc} + {5'd0, r_quo};
    assign sum_sat = sum_w[23] ? ACC_MAX : sum_w[22:0];

    assign o_pair_pop = (r_state == S_IDLE) && i_pair_valid;
    assign o_req.valid = (r_state == S_ACC) && r_last;
    assign o_req.sum   = sum_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_pair_valid) begin
                        r_diff  <= i_pair.diff;
                        r_total <= i_pair.total;
                        r_last  <= i_pair.last;
                        r_quo   <= '0;
                        // a zero pair sum adds nothing
                        r_state <= (i_pair.total == '0) ? S_ACC : S_MUL;
                    end
                end
                S_MUL: begin
                    // dividend is 4*d*d; top bits start the remainder
                    r_rem   <= {2'b00, prod[31:17]};
                    r_low   <= {prod[16:0], 2'b00};
                    r_cnt   <= TERM_STEPS;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= ge ? diff_t[16:0] : trial[16:0];
                    r_low <= {r_low[17:0], 1'b0};
                    r_quo <= {r_quo[17:0], ge};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (!r_last) begin
                        r_acc   <= sum_sat;
                        r_state <= S_IDLE;
                    end else if (i_req_ready) begin
                        r_acc   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/ecsk_exp.sv]
// exponential unit: exp(-gamma*sum) by taylor series and exp(-1) powers
// depends on ecsk_pkg
`timescale 1ns / 1ps
`default_nettype none

module ecsk_exp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_gamma,
    input  ecsk_pkg::t_sum_req  i_req,
    output logic                o_req_ready,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [16:0]         o_kernel_value,
    output logic [22:0]         o_chi_sum
);
    import ecsk_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE, E_PMUL, E_CHK, E_TMUL, E_DIV, E_TADD, E_SDONE,
        E_RLOOP, E_ROUND, E_OUT
    } t_state;

    t_state             r_state;
    logic [22:0]        r_sum;
    logic [38:0]        r_p;
    logic [3:0]         r_n;
    logic [30:0]        r_f;
    logic [30:0]        r_term;
    logic signed [32:0] r_ser;
    logic [4:0]         r_k;
    logic [30:0]        r_dvd;
    logic [4:0]         r_rem;
    logic [4:0]         r_cnt;
    logic [30:0]        r_e1;
    logic               r_e1_ok;
    logic               r_mode_e1;
    logic [30:0]        r_r;

    logic [61:0]        term_prod;
    logic [61:0]        pow_prod;
    logic [5:0]         trial;
    logic               ge;
    logic [5:0]         diff_t;
    logic signed [32:0] dvd_s;
    logic [30:0]        ser_val;
    logic [31:0]        rnd_sum;
    logic [17:0]        rnd;

    assign term_prod = r_term * r_f;
    assign pow_prod  = r_r * r_e1;
    assign trial     = {r_rem, r_dvd[30]};
    assign ge        = (trial >= {1'b0, r_k});
    assign diff_t    = trial - {1'b0, r_k};
    assign dvd_s     = $signed({2'b00, r_dvd});
    assign ser_val   = r_ser[32] ? '0 : r_ser[30:0];
    assign rnd_sum   = {1'b0, r_r} + ROUND_BIAS;
    assign rnd       = rnd_sum[31:14];

    assign o_req_ready = (r_state == E_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= E_IDLE;
            r_e1_ok   <= 1'b0;
            r_mode_e1 <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            unique case (r_state)
                E_IDLE: begin
                    if (i_req.valid) begin
                        r_sum   <= i_req.sum;
                        r_state <= E_PMUL;
                    end
                end
                E_PMUL: begin
                    r_p     <= i_gamma * r_sum;
                    r_state <= E_CHK;
                end
                E_CHK: begin
                    r_term <= ONE_Q30;
                    r_ser  <= $signed({2'b00, ONE_Q30});
                    r_k    <= 5'd1;
                    r_n    <= r_p[31:28];
                    if (r_p[38:28] >= EXP_CUTOFF) begin
                        // below half an lsb
                        r_r     <= '0;
                        r_state <= E_ROUND;
                    end else if (!r_e1_ok) begin
                        // exp(-1) worked out once with the same series
                        r_f       <= ONE_Q30;
                        r_mode_e1 <= 1'b1;
                        r_state   <= E_TMUL;
                    end else begin
                        r_f       <= {1'b0, r_p[27:0], 2'b00};
                        r_mode_e1 <= 1'b0;
                        r_state   <= E_TMUL;
                    end
                end
                E_TMUL: begin
                    r_dvd   <= term_prod[60:30];
                    r_rem   <= '0;
                    r_cnt   <= SER_STEPS;
                    r_state <= E_DIV;
                end
                E_DIV: begin
                    r_rem <= ge ? diff_t[4:0] : trial[4:0];
                    r_dvd <= {r_dvd[29:0], ge};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_state <= E_TADD;
                    end
                end
                E_TADD: begin
                    r_term <= r_dvd;
                    r_ser  <= r_k[0] ? (r_ser - dvd_s) : (r_ser + dvd_s);
                    if (r_k == N_TERMS) begin
                        r_state <= E_SDONE;
                    end else begin
                        r_k     <= r_k + 5'd1;
                        r_state <= E_TMUL;
                    end
                end
                E_SDONE: begin
                    if (r_mode_e1) begin
                        r_e1      <= ser_val;
                        r_e1_ok   <= 1'b1;
                        r_mode_e1 <= 1'b0;
                        r_f       <= {1'b0, r_p[27:0], 2'b00};
                        r_term    <= ONE_Q30;
                        r_ser     <= $signed({2'b00, ONE_Q30});
                        r_k       <= 5'd1;
                        r_state   <= E_TMUL;
                    end else begin
                        r_r     <= ser_val;
                        r_state <= E_RLOOP;
                    end
                end
                E_RLOOP: begin
                    if (r_n == 4'd0) begin
                        r_state <= E_ROUND;
                    end else begin
                        r_r <= pow_prod[60:30];
                        r_n <= r_n - 4'd1;
                    end
                end
                E_ROUND: begin
                    o_kernel_value <= (rnd > KERNEL_ONE) ? KERNEL_ONE[16:0] : rnd[16:0];
                    o_chi_sum      <= r_sum;
                    o_valid        <= 1'b1;
                    r_state        <= E_OUT;
                end
                E_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= E_IDLE;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/exp_chi_squared_kernel.sv]
// top level of the exponential chi-squared kernel
// depends on ecsk_pkg, ecsk_front, ecsk_accum, ecsk_exp
//
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_x_value, i_y_value, i_last_element
// result    out        o_valid / i_stall      o_kernel_value, o_chi_sum
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_gamma
//
// a non-last pair passes the back end as one product, 19 shift-subtract
// quotient steps and one saturating add; a zero-sum pair skips to the add
// a last pair adds the exponential: 20 series terms in the shared
// multiply and divide-by-k loop, plus up to 11 exp(-1) products;
// the first result under the cutoff after reset also runs the series for exp(-1)
// the front queue keeps taking transactions while the back end works
// reset is synchronous, active low; gamma returns to 0.5 and the sum to 0
// a stalled result holds in the output register of the exponential unit
`timescale 1ns / 1ps
`default_nettype none

module exp_chi_squared_kernel #(
    parameter int QUEUE_DEPTH = 4   // power of two, 2 to 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // element pair transactions
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_x_value,
    input  logic [15:0] i_y_value,
    input  logic        i_last_element,
    // result transactions
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_kernel_value,
    output logic [22:0] o_chi_sum,
    // gamma register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_gamma
);
    import ecsk_pkg::*;

    logic [15:0] r_gamma;
    logic        pair_valid;
    t_pair       pair;
    logic        pair_pop;
    t_sum_req    sum_req;
    logic        req_ready;

    // gamma must be written by the user only while idle; the block does not enforce it, so it is always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gamma <= i_cfg_gamma;
        end
    end

    // classify and queue pairs
    ecsk_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .i_last_element (i_last_element),
        .o_pair_valid   (pair_valid),
        .o_pair         (pair),
        .i_pair_pop     (pair_pop)
    );

    // chi-squared terms and saturating accumulation
    ecsk_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (pair_valid),
        .i_pair       (pair),
        .o_pair_pop   (pair_pop),
        .o_req        (sum_req),
        .i_req_ready  (req_ready)
    );

    // kernel value and result register
    ecsk_exp u_exp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_gamma        (r_gamma),
        .i_req          (sum_req),
        .o_req_ready    (req_ready),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kernel_value (o_kernel_value),
        .o_chi_sum      (o_chi_sum)
    );

endmodule

`default_nettype wire

[rtl/core/ecsk_checker.sv]
// port-level checks of the exponential chi-squared kernel, with bind
// depends on exp_chi_squared_kernel_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "exp_chi_squared_kernel_defines.svh"

module ecsk_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [16:0] o_kernel_value,
    input  logic [22:0] o_chi_sum
);

    // a stalled result stays offered
    `ECSK_ASSERT(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)
    // kernel never above 1.0
    `ECSK_ASSERT(a_bound, i_clk, i_rst_n, o_valid |-> o_kernel_value <= 17'd65536)
    // zero distance gives exactly 1.0
    `ECSK_ASSERT(a_one, i_clk, i_rst_n, o_valid && o_chi_sum == 23'd0 |-> o_kernel_value == 17'd65536)
    // reset drops any result
    `ECSK_ASSERT_RST(a_rst, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind exp_chi_squared_kernel ecsk_checker u_ecsk_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kernel_value (o_kernel_value),
    .o_chi_sum      (o_chi_sum)
);

`default_nettype wire

[verif/tb.sv]
// self-checking testbench of the exponential chi-squared kernel
// depends on exp_chi_squared_kernel and its package ecsk_pkg; predicts each result itself
`timescale 1ns / 1ps

module tb;

    // expected result of one finished vector pair
    typedef struct {
        logic [16:0] kernel;
        logic [22:0] chi_sum;
    } t_kernel_result;

    localparam logic [22:0] SUM_LIMIT  = 23'h7F_FFFF;
    localparam longint      Q30_ONE    = 64'd1073741824;
    localparam longint      FRAC_MASK  = 64'd268435455;
    localparam int          TAIL_WAIT  = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_x_value = '0;
    logic [15:0] i_y_value = '0;
    logic        i_last_element = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [16:0] o_kernel_value;
    logic [22:0] o_chi_sum;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_gamma = '0;

    // predictor state
    logic [15:0]    gamma_q = 16'd2048;
    logic [22:0]    distance_sum = '0;
    t_kernel_result pending_results[$];
    int             fail_count = 0;
    bit             quiet = 1'b0;      // no idling in the last part
    bit             hold_request = 1'b0;

    always #4 i_clk = ~i_clk;

    exp_chi_squared_kernel u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kernel_value (o_kernel_value),
        .o_chi_sum      (o_chi_sum),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_gamma    (i_cfg_gamma)
    );

    // exp(-f), f and result in Q2.30, truncated taylor series
    function automatic longint exp_series(longint f);
        longint term;
        longint acc;
        term = Q30_ONE;
        acc  = Q30_ONE;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * f) >>> 30) / k;
            if (k % 2 == 1) acc = acc - term;
            else            acc = acc + term;
        end
        return (acc < 0) ? 64'd0 : acc;
    endfunction

    // exp(-gamma*sum) in Q1.16, rounded to nearest
    function automatic logic [16:0] kernel_estimate(logic [15:0] g, logic [22:0] s);
        longint prod;
        longint whole;
        longint r;
        longint e1;
        prod  = longint'(g) * longint'(s);
        whole = prod >>> 28;
        if (whole >= 12) return 17'd0;
        r  = exp_series((prod & FRAC_MASK) << 2);
        e1 = exp_series(Q30_ONE);
        for (longint i = 0; i < whole; i++) r = (r * e1) >>> 30;
        r = (r + 8192) >>> 14;
        if (r > 65536) r = 65536;
        return r[16:0];
    endfunction

    // fold one accepted pair into the predicted sum, queue a result on the last pair
    task automatic predict_pair(logic [15:0] x, logic [15:0] y, logic last);
        longint s;
        longint d;
        longint acc;
        t_kernel_result res;
        s = longint'(x) + longint'(y);
        if (s != 0) begin
            d   = (x >= y) ? longint'(x - y) : longint'(y - x);
            acc = longint'(distance_sum) + (4 * d * d) / s;
            distance_sum = (acc > longint'(SUM_LIMIT)) ? SUM_LIMIT : acc[22:0];
        end
        if (last) begin
            res.kernel  = kernel_estimate(gamma_q, distance_sum);
            res.chi_sum = distance_sum;
            pending_results.push_back(res);
            distance_sum = '0;
        end
    endtask

    // one pair transaction, with an occasional idle burst first
    task automatic send_pair(logic [15:0] x, logic [15:0] y, logic last);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_x_value      = x;
        i_y_value      = y;
        i_last_element = last;
        do @(posedge i_clk); while (o_stall);
        predict_pair(x, y, last);
    endtask

    task automatic end_stream();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // waits for every result, then lets the back end settle
    task automatic wait_drained();
        end_stream();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    task automatic write_gamma(logic [15:0] g);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_gamma = g;
        do @(posedge i_clk); while (!o_cfg_ready);
        gamma_q = g;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // random element, mostly in [0,1], sometimes across the full 16 bits
    function automatic logic [15:0] rand_element();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'd0;
            2:       return 16'd32768;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic send_vector(int len);
        for (int i = 0; i < len; i++)
            send_pair(rand_element(), rand_element(), i == len - 1);
    endtask

    // extremes of the elements, zero-sum pairs, elements above one
    task automatic test_directed();
        send_pair(16'd0, 16'd0, 1'b1);
        send_pair(16'd32768, 16'd0, 1'b1);
        send_pair(16'd0, 16'd32768, 1'b1);
        send_pair(16'd65535, 16'd65535, 1'b1);
        send_pair(16'd0, 16'd0, 1'b0);
        send_pair(16'd65535, 16'd0, 1'b1);
        send_pair(16'd12345, 16'd54321, 1'b0);
        send_pair(16'd0, 16'd0, 1'b1);
        send_pair(16'd1, 16'd0, 1'b1);
    endtask

    // saturation of the sum and a large exponent at maximum gamma
    task automatic test_saturation();
        for (int i = 0; i < 34; i++) send_pair(16'd65535, 16'd0, i == 33);
        send_pair(16'd32768, 16'd16384, 1'b1);
    endtask

    task automatic test_random(int pairs);
        int sent;
        sent = 0;
        while (sent < pairs) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_vector(len);
            sent += len;
        end
    endtask

    // receiver holds off long enough for the input queue to fill
    task automatic test_backpressure();
        hold_request = 1'b1;
        test_random(60);
    endtask

    // result stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall = 1'b1;
                for (int c = 0; c < 3000; c++) @(negedge i_clk);
                i_stall = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                i_stall = 1'b0;
            end else if (!quiet && $urandom_range(0, 40) == 0) begin
                repeat ($urandom_range(20, 80)) @(negedge i_clk);
            end
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kernel %0d sum %0d",
                         $time, o_kernel_value, o_chi_sum);
                fail_count++;
            end else begin
                t_kernel_result want;
                int diff;
                want = pending_results.pop_front();
                diff = int'(o_kernel_value) - int'(want.kernel);
                // the exponential may be off by one lsb
                if (diff > 1 || diff < -1) begin
                    $display("%0t: kernel_value expected %0d actual %0d",
                             $time, want.kernel, o_kernel_value);
                    fail_count++;
                end
                if (o_chi_sum !== want.chi_sum) begin
                    $display("%0t: chi_sum expected %0d actual %0d",
                             $time, want.chi_sum, o_chi_sum);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        write_gamma(16'd0);
        test_directed();
        write_gamma(16'd65535);
        test_saturation();
        test_directed();
        write_gamma(16'd4096);
        test_backpressure();
        test_random(700);
        write_gamma(16'($urandom_range(1, 65534)));
        test_random(700);
        write_gamma(16'd2048);
        quiet = 1'b1;
        test_random(400);
        end_stream();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
